FILE: src/rpu_pkg.sv
// Package for the rain particle update block: constants, widths, types.
// No dependencies.
package rpu_pkg;

  localparam int CoordW = 32;
  localparam int CntW = 9;
  localparam int UnitAw = 8;
  localparam int NumUnits = 256;

  localparam logic [CoordW-1:0] FallXz = 32'(120 * 256);
  localparam logic [CoordW-1:0] FallY0 = 32'(370 * 256);
  localparam logic [17:0] FallSpan = 18'(320 * 256);
  localparam logic [CoordW-1:0] JitBase = 32'(80 * 256);
  localparam logic [15:0] RatioBase = 16'd3277;
  localparam logic [15:0] RatioSpan = 16'd6554;
  localparam logic [31:0] LfsrMask = 32'h8020_0003;
  localparam logic [31:0] LfsrSeed = 32'hACE1_ACE1;

  localparam logic [3:0] RegMinX = 4'd0;
  localparam logic [3:0] RegMinY = 4'd1;
  localparam logic [3:0] RegMinZ = 4'd2;
  localparam logic [3:0] RegMaxX = 4'd3;
  localparam logic [3:0] RegMaxY = 4'd4;
  localparam logic [3:0] RegMaxZ = 4'd5;
  localparam logic [3:0] RegActive = 4'd6;
  localparam logic [3:0] RegUnits = 4'd7;

  // Datapath operation codes issued by the controller.
  typedef enum logic [3:0] {
    OpNone,
    OpDivStart,   // start ratio and fall divisions, read wind slot
    OpDivStep,    // one restoring division step
    OpWindMul,    // wind delta products
    OpWindUpd,    // write wind, latch step vector
    OpPartLoad,   // latch particle item, do box test
    OpDraw,       // advance LFSR, multiply one axis
    OpAxisDone,   // add one axis result
    OpEmit        // load output register
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic frozen;
    logic respawn;
    logic out_busy;
  } stat_t;

  // One Galois LFSR step.
  function automatic logic [31:0] lfsr_next(input logic [31:0] s);
    logic [31:0] n;
    n = {1'b0, s[31:1]};
    if (s[0]) n = n ^ LfsrMask;
    return n;
  endfunction

endpackage

FILE: src/rpu_ctrl.sv
// Controller for the rain particle update block.
// Depends on rpu_pkg; drives datapath commands, reads its status.
module rpu_ctrl import rpu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid,
  output logic  in_stall,
  input  logic  in_cmd_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    SIdle, SDiv, SWindMul, SWindUpd, SPart, SDraw, SAxis, SEmit
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] axis_q, axis_d;

  always_comb begin
    state_d  = state_q;
    axis_d   = axis_q;
    cmd_o    = '{op: OpNone, axis: axis_q};
    in_stall = 1'b1;
    case (state_q)
      SIdle: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_cmd_i) begin
            cmd_o.op = OpPartLoad;
            state_d  = SPart;
          end else begin
            cmd_o.op = OpDivStart;
            state_d  = SDiv;
          end
        end
      end
      SDiv: begin
        cmd_o.op = OpDivStep;
        if (stat_i.div_done) state_d = SWindMul;
      end
      SWindMul: begin
        cmd_o.op = OpWindMul;
        state_d  = SWindUpd;
      end
      SWindUpd: begin
        cmd_o.op = OpWindUpd;
        state_d  = SIdle;
      end
      SPart: begin
        axis_d = 2'd0;
        state_d = stat_i.frozen ? SEmit : SDraw;
      end
      SDraw: begin
        cmd_o.op = OpDraw;
        state_d  = SAxis;
      end
      SAxis: begin
        cmd_o.op = OpAxisDone;
        if (axis_q == 2'd2) begin
          state_d = SEmit;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = SDraw;
        end
      end
      SEmit: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = OpEmit;
          state_d  = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      axis_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    axis_q != 2'd3) else $error("axis counter out of range");
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && !in_stall) |=> state_q != SIdle) else $error("accept did not start work");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == OpEmit |-> !stat_i.out_busy) else $error("emit into full output");

endmodule

FILE: src/rpu_dp.sv
// Datapath for the rain particle update block: registers, wind table,
// serial divider, LFSR, multiplier and output register. Depends on rpu_pkg.
module rpu_dp import rpu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_idx,
  input  logic [CoordW-1:0]  cfg_wdata,
  input  logic               first_i,
  input  logic signed [CoordW-1:0] wind_x_i,
  input  logic signed [CoordW-1:0] wind_z_i,
  input  logic signed [CoordW-1:0] old_x_i,
  input  logic signed [CoordW-1:0] old_y_i,
  input  logic signed [CoordW-1:0] old_z_i,
  input  logic signed [CoordW-1:0] pb_x_i,
  input  logic signed [CoordW-1:0] pb_y_i,
  input  logic signed [CoordW-1:0] pb_z_i,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [CoordW-1:0] top_x_o,
  output logic signed [CoordW-1:0] top_y_o,
  output logic signed [CoordW-1:0] top_z_o,
  output logic signed [CoordW-1:0] bot_x_o,
  output logic signed [CoordW-1:0] bot_y_o,
  output logic signed [CoordW-1:0] bot_z_o,
  output logic               resp_o,
  output logic               frz_o
);

  logic signed [CoordW-1:0] bmin_q [3];
  logic signed [CoordW-1:0] bmax_q [3];
  logic [CntW-1:0] act_q, units_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        bmin_q[i] <= '0;
        bmax_q[i] <= '0;
      end
      act_q   <= 9'd256;
      units_q <= 9'd1;
    end else if (cfg_we) begin
      case (cfg_idx)
        RegMinX:   bmin_q[0] <= cfg_wdata;
        RegMinY:   bmin_q[1] <= cfg_wdata;
        RegMinZ:   bmin_q[2] <= cfg_wdata;
        RegMaxX:   bmax_q[0] <= cfg_wdata;
        RegMaxY:   bmax_q[1] <= cfg_wdata;
        RegMaxZ:   bmax_q[2] <= cfg_wdata;
        RegActive: act_q <= cfg_wdata[CntW-1:0];
        RegUnits:  units_q <= cfg_wdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  // Wind table with valid bits: invalid entry reads as zero.
  logic [2*CoordW-1:0] wind_mem [NumUnits];
  logic [NumUnits-1:0] wvld_q;
  logic [2*CoordW-1:0] wrd_q;
  logic                wrd_vld_q;
  logic [UnitAw-1:0]   slot_q;

  logic [CntW-1:0]   uidx_q;
  logic [CntW-1:0]   pidx_q;
  logic [CoordW-1:0] fall_q;
  logic [CoordW-1:0] step_q [3];
  logic [31:0]       rnd_q;

  // Serial division: quotients of 6554*uidx/n and 81920/n.
  logic [CntW-1:0]  div_n_q;
  logic [22:0]      rat_num_q;
  logic [CntW:0]    rat_rem_q;
  logic [17:0]      fal_num_q;
  logic [CntW:0]    fal_rem_q;
  logic [4:0]       div_cnt_q;
  logic [CntW:0]    rat_tr, fal_tr;
  logic             rat_ge, fal_ge;
  logic [CntW-1:0]  uidx_use;

  assign uidx_use = first_i ? '0 : uidx_q;
  assign rat_tr = {rat_rem_q[CntW-1:0], rat_num_q[22]};
  assign fal_tr = {fal_rem_q[CntW-1:0], fal_num_q[17]};
  assign rat_ge = rat_tr >= {1'b0, div_n_q};
  assign fal_ge = fal_tr >= {1'b0, div_n_q};

  // Wind delta products. Unit index may run past the unit count, so the
  // ratio keeps the full quotient width.
  logic signed [CoordW-1:0] wind_x_q, wind_z_q;
  logic signed [CoordW:0]   dx_w, dz_w;
  logic signed [CoordW+17:0] px_q, pz_q;
  logic signed [CoordW-1:0] wx_old, wz_old;
  logic [22:0] ratio;
  assign wx_old = wrd_vld_q ? wrd_q[2*CoordW-1:CoordW] : '0;
  assign wz_old = wrd_vld_q ? wrd_q[CoordW-1:0] : '0;
  assign ratio = 23'(RatioBase) + rat_num_q;
  assign dx_w = {wind_x_q[CoordW-1], wind_x_q} - {wx_old[CoordW-1], wx_old};
  assign dz_w = {wind_z_q[CoordW-1], wind_z_q} - {wz_old[CoordW-1], wz_old};

  logic signed [CoordW-1:0] nwx, nwz;
  assign nwx = wx_old + CoordW'(px_q >>> 16);
  assign nwz = wz_old + CoordW'(pz_q >>> 16);

  // Particle registers.
  logic signed [CoordW-1:0] pb_q [3];
  logic signed [CoordW-1:0] res_q [3];
  logic frz_q, resp_q;
  logic [1:0] ax;
  assign ax = cmd_i.axis;

  logic [31:0] rnd_n;
  assign rnd_n = lfsr_next(rnd_q);
  logic signed [CoordW:0]    span_w;
  logic signed [CoordW+17:0] rp_q;
  assign span_w = {bmax_q[ax][CoordW-1], bmax_q[ax]} - {bmin_q[ax][CoordW-1], bmin_q[ax]};

  logic outside;
  always_comb begin
    outside = 1'b0;
    if (old_x_i < bmin_q[0] || old_x_i > bmax_q[0]) outside = 1'b1;
    if (old_y_i < bmin_q[1] || old_y_i > bmax_q[1]) outside = 1'b1;
    if (old_z_i < bmin_q[2] || old_z_i > bmax_q[2]) outside = 1'b1;
  end

  logic ovld_q;
  assign stat_o = '{div_done: div_cnt_q == 5'd23, frozen: frz_q,
                    respawn: resp_q, out_busy: ovld_q && out_stall};

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OpDivStart) begin
      wrd_q <= wind_mem[uidx_use[UnitAw-1:0]];
      wind_x_q <= wind_x_i;
      wind_z_q <= wind_z_i;
    end
    if (cmd_i.op == OpWindUpd) wind_mem[slot_q] <= {nwx, nwz};
    if (cmd_i.op == OpWindMul) begin
      px_q <= dx_w * $signed({1'b0, ratio});
      pz_q <= dz_w * $signed({1'b0, ratio});
    end
    if (cmd_i.op == OpPartLoad) begin
      pb_q[0] <= pb_x_i;   pb_q[1] <= pb_y_i;   pb_q[2] <= pb_z_i;
      resp_q <= outside;
    end
    if (cmd_i.op == OpDraw) begin
      if (resp_q) rp_q <= span_w * $signed({2'b0, rnd_n[31:16]});
      else rp_q <= (CoordW+18)'(JitBase) * (CoordW+18)'(rnd_n[31:16]);
    end
    if (cmd_i.op == OpAxisDone) begin
      if (resp_q) res_q[ax] <= bmin_q[ax] + CoordW'(rp_q >>> 16);
      else res_q[ax] <= pb_q[ax] + step_q[ax] + JitBase + CoordW'(rp_q >>> 16);
    end
    if (cmd_i.op == OpEmit) begin
      top_x_o <= (resp_q && !frz_q) ? res_q[0] : pb_q[0];
      top_y_o <= (resp_q && !frz_q) ? res_q[1] : pb_q[1];
      top_z_o <= (resp_q && !frz_q) ? res_q[2] : pb_q[2];
      bot_x_o <= frz_q ? pb_q[0] : res_q[0];
      bot_y_o <= frz_q ? pb_q[1] : res_q[1];
      bot_z_o <= frz_q ? pb_q[2] : res_q[2];
      resp_o  <= resp_q && !frz_q;
      frz_o   <= frz_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvld_q    <= '0;
      wrd_vld_q <= 1'b0;
      slot_q    <= '0;
      uidx_q    <= '0;
      pidx_q    <= '0;
      fall_q    <= FallY0;
      step_q[0] <= '0; step_q[1] <= '0; step_q[2] <= '0;
      rnd_q     <= LfsrSeed;
      div_n_q   <= 9'd1;
      rat_num_q <= '0; rat_rem_q <= '0;
      fal_num_q <= '0; fal_rem_q <= '0;
      div_cnt_q <= '0;
      frz_q     <= 1'b0;
      ovld_q    <= 1'b0;
    end else begin
      if (ovld_q && !out_stall) ovld_q <= 1'b0;
      case (cmd_i.op)
        OpDivStart: begin
          div_n_q   <= (units_q == '0) ? 9'd1 : units_q;
          rat_num_q <= 23'(RatioSpan) * 23'(uidx_use);
          rat_rem_q <= '0;
          fal_num_q <= FallSpan;
          fal_rem_q <= '0;
          div_cnt_q <= '0;
          slot_q    <= uidx_use[UnitAw-1:0];
          wrd_vld_q <= wvld_q[uidx_use[UnitAw-1:0]];
          uidx_q    <= uidx_use;
          if (first_i) fall_q <= FallY0;
        end
        OpDivStep: begin
          if (div_cnt_q != 5'd23) begin
            div_cnt_q <= div_cnt_q + 5'd1;
            rat_rem_q <= rat_ge ? rat_tr - {1'b0, div_n_q} : rat_tr;
            rat_num_q <= {rat_num_q[21:0], rat_ge};
            if (div_cnt_q < 5'd18) begin
              fal_rem_q <= fal_ge ? fal_tr - {1'b0, div_n_q} : fal_tr;
              fal_num_q <= {fal_num_q[16:0], fal_ge};
            end
          end
        end
        OpWindUpd: begin
          wvld_q[slot_q] <= 1'b1;
          step_q[0] <= nwx - FallXz;
          step_q[1] <= '0 - fall_q;
          step_q[2] <= nwz - FallXz;
          fall_q    <= fall_q + CoordW'(fal_num_q);
          uidx_q    <= uidx_q + 9'd1;
          pidx_q    <= '0;
        end
        OpPartLoad: begin
          frz_q <= pidx_q >= act_q;
          if (pidx_q != 9'd511) pidx_q <= pidx_q + 9'd1;
        end
        OpDraw: rnd_q <= rnd_n;
        OpEmit: ovld_q <= 1'b1;
        default: ;
      endcase
    end
  end

  assign out_valid = ovld_q;

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_cnt_q <= 5'd23) else $error("divider count overrun");
  a_div_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_n_q != '0) else $error("zero divisor");
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OpEmit |=> ovld_q) else $error("emit lost");

endmodule

FILE: src/rain_particle_update.sv
// Rain particle update: one unit-start or particle item at a time.
// Unit start: a 23-step serial divider, then wind products and wind update.
//   Particle: box test, then the output register directly when frozen, or
//   three axis draws through one shared multiplier when moving or respawned.
// Throughput: next item accepted once the previous one's result is loaded or its wind update written.
// Reset: async active-low; wind table cleared via per-entry valid bits.
module rain_particle_update import rpu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd_i,
  input  logic        first_of_frame_i,
  input  logic signed [31:0] wind_x_i,
  input  logic signed [31:0] wind_z_i,
  input  logic signed [31:0] old_x_i,
  input  logic signed [31:0] old_y_i,
  input  logic signed [31:0] old_z_i,
  input  logic signed [31:0] prev_bottom_x_i,
  input  logic signed [31:0] prev_bottom_y_i,
  input  logic signed [31:0] prev_bottom_z_i,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_idx,
  input  logic [31:0] cfg_wdata,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] top_x_o,
  output logic signed [31:0] top_y_o,
  output logic signed [31:0] top_z_o,
  output logic signed [31:0] bottom_x_o,
  output logic signed [31:0] bottom_y_o,
  output logic signed [31:0] bottom_z_o,
  output logic        respawned_o,
  output logic        frozen_o
);

  cmd_t  cmd;
  stat_t stat;

  // Controller sequences division, wind update and per-axis draws.
  rpu_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall,
    .in_cmd_i(cmd_i), .stat_i(stat), .cmd_o(cmd)
  );

  rpu_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .cfg_we, .cfg_idx, .cfg_wdata,
    .first_i(first_of_frame_i), .wind_x_i, .wind_z_i,
    .old_x_i, .old_y_i, .old_z_i,
    .pb_x_i(prev_bottom_x_i), .pb_y_i(prev_bottom_y_i), .pb_z_i(prev_bottom_z_i),
    .out_valid, .out_stall,
    .top_x_o, .top_y_o, .top_z_o,
    .bot_x_o(bottom_x_o), .bot_y_o(bottom_y_o), .bot_z_o(bottom_z_o),
    .resp_o(respawned_o), .frz_o(frozen_o)
  );

endmodule

FILE: dv/tb_rain_particle_update.sv
// Testbench for rain_particle_update: random and directed unit-start and particle items,
// checked against an in-bench predictor of wind easing, fall offset, LFSR respawn and jitter.
// Depends on rpu_pkg and the rain_particle_update RTL.
`timescale 1ns / 1ps

module tb_rain_particle_update;
  import rpu_pkg::*;

  typedef enum logic {CmdUnit = 1'b0, CmdPart = 1'b1} cmd_e;

  typedef struct packed {
    logic        cmd;
    logic        first;
    logic [31:0] wx, wz, ox, oy, oz, bx, by, bz;
  } item_t;

  typedef struct packed {
    logic [31:0] tx, ty, tz, nx, ny, nz;
    logic        resp, frz;
  } seg_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #10 clk_i = ~clk_i;

  // DUT ports
  logic        in_valid = 1'b0;
  logic        in_stall;
  item_t       cur = '0;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_idx = '0;
  logic [31:0] cfg_wdata = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [31:0] top_x_o, top_y_o, top_z_o, bottom_x_o, bottom_y_o, bottom_z_o;
  logic        respawned_o, frozen_o;

  rain_particle_update u_top (
    .clk_i, .rst_ni, .in_valid, .in_stall,
    .cmd_i(cur.cmd), .first_of_frame_i(cur.first),
    .wind_x_i(cur.wx), .wind_z_i(cur.wz),
    .old_x_i(cur.ox), .old_y_i(cur.oy), .old_z_i(cur.oz),
    .prev_bottom_x_i(cur.bx), .prev_bottom_y_i(cur.by), .prev_bottom_z_i(cur.bz),
    .cfg_we, .cfg_idx, .cfg_wdata,
    .out_valid, .out_stall,
    .top_x_o, .top_y_o, .top_z_o, .bottom_x_o, .bottom_y_o, .bottom_z_o,
    .respawned_o, .frozen_o
  );

  // ---------------- predictor state ----------------
  logic signed [31:0] bmin [3];
  logic signed [31:0] bmax [3];
  int unsigned        n_active, n_units;
  logic signed [31:0] wind_x_tab [NumUnits];
  logic signed [31:0] wind_z_tab [NumUnits];
  logic signed [31:0] fall_y;
  logic signed [31:0] stepv [3];
  int unsigned        unit_idx, part_idx;
  logic [31:0]        lfsr;

  seg_t expected_segs[$];
  item_t pending_items[$];
  int errors = 0;
  int n_checked = 0, n_resp = 0, n_frz = 0;

  // floor(v / 65536) on a 64-bit signed product: arithmetic shift floors
  function automatic longint q16_floor(longint v);
    return v >>> 16;
  endfunction

  function automatic longint next_frac();
    lfsr = {1'b0, lfsr[31:1]} ^ (lfsr[0] ? LfsrMask : 32'h0);
    return longint'(lfsr[31:16]);
  endfunction

  task automatic model_reset();
    for (int i = 0; i < 3; i++) begin
      bmin[i] = '0;
      bmax[i] = '0;
      stepv[i] = '0;
    end
    n_active = 256;
    n_units = 1;
    for (int i = 0; i < NumUnits; i++) begin
      wind_x_tab[i] = '0;
      wind_z_tab[i] = '0;
    end
    fall_y = FallY0;
    unit_idx = 0;
    part_idx = 0;
    lfsr = LfsrSeed;
  endtask

  task automatic model_cfg(logic [3:0] idx, logic [31:0] val);
    case (idx)
      RegMinX: bmin[0] = val;
      RegMinY: bmin[1] = val;
      RegMinZ: bmin[2] = val;
      RegMaxX: bmax[0] = val;
      RegMaxY: bmax[1] = val;
      RegMaxZ: bmax[2] = val;
      RegActive: n_active = val[8:0];
      RegUnits: n_units = val[8:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] ease(logic signed [31:0] stored,
                                              logic signed [31:0] tgt, longint ratio);
    longint d;
    d = (longint'(tgt) - longint'(stored)) * ratio;
    return 32'(longint'(stored) + q16_floor(d));
  endfunction

  // Work out what one accepted item produces; unit starts yield nothing.
  task automatic predict_segment(item_t it);
    longint n, ratio, r;
    int slot;
    logic signed [31:0] o [3];
    logic signed [31:0] b [3];
    seg_t s;
    logic outside;
    if (it.cmd == CmdUnit) begin
      n = (n_units == 0) ? 1 : n_units;
      if (it.first) begin
        fall_y = FallY0;
        unit_idx = 0;
      end
      slot = unit_idx % NumUnits;
      ratio = longint'(RatioBase) + (longint'(RatioSpan) * unit_idx) / n;
      wind_x_tab[slot] = ease(wind_x_tab[slot], it.wx, ratio);
      wind_z_tab[slot] = ease(wind_z_tab[slot], it.wz, ratio);
      stepv[0] = wind_x_tab[slot] - FallXz;
      stepv[1] = -fall_y;
      stepv[2] = wind_z_tab[slot] - FallXz;
      fall_y = 32'(longint'(fall_y) + longint'(FallSpan) / n);
      unit_idx = (unit_idx + 1) & 9'h1FF;
      part_idx = 0;
      return;
    end
    o = '{it.ox, it.oy, it.oz};
    b = '{it.bx, it.by, it.bz};
    s = '0;
    if (part_idx >= n_active) begin
      s.frz = 1'b1;
      {s.tx, s.ty, s.tz} = {b[0], b[1], b[2]};
      {s.nx, s.ny, s.nz} = {b[0], b[1], b[2]};
    end else begin
      outside = 1'b0;
      for (int a = 0; a < 3; a++)
        if (o[a] < bmin[a] || o[a] > bmax[a]) outside = 1'b1;
      if (outside) begin
        s.resp = 1'b1;
        for (int a = 0; a < 3; a++) begin
          r = next_frac();
          o[a] = 32'(longint'(bmin[a])
                     + q16_floor((longint'(bmax[a]) - longint'(bmin[a])) * r));
        end
        {s.tx, s.ty, s.tz} = {o[0], o[1], o[2]};
        {s.nx, s.ny, s.nz} = {o[0], o[1], o[2]};
      end else begin
        {s.tx, s.ty, s.tz} = {b[0], b[1], b[2]};
        for (int a = 0; a < 3; a++) begin
          r = next_frac();
          o[a] = b[a] + stepv[a] + 32'(longint'(JitBase) + q16_floor(longint'(JitBase) * r));
        end
        {s.nx, s.ny, s.nz} = {o[0], o[1], o[2]};
      end
    end
    if (part_idx < 511) part_idx++;
    expected_segs.push_back(s);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h (segment %0d)", what, got, want, n_checked);
  endtask

  // ---------------- idling control ----------------
  logic quiet = 1'b0;      // long stretch without idling
  int   hold_left = 0;     // receiver hold-off in cycles
  logic want_hold = 1'b0;

  // ---------------- driver ----------------
  // Valid held while the item is not yet taken; next item loaded in the same step.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) predict_segment(cur);
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && (quiet || $urandom_range(99) >= 15)) begin
          cur <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- receiver stall ----------------
  always @(posedge clk_i) begin
    if (want_hold && hold_left == 0) begin
      hold_left = 200;
      want_hold <= 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 15);
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk_i) begin
    seg_t w;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_segs.size() == 0) begin
        errors++;
        $display("unexpected segment, none pending");
      end else begin
        w = expected_segs.pop_front();
        if (top_x_o !== w.tx) report_mismatch("top_x", top_x_o, w.tx);
        if (top_y_o !== w.ty) report_mismatch("top_y", top_y_o, w.ty);
        if (top_z_o !== w.tz) report_mismatch("top_z", top_z_o, w.tz);
        if (bottom_x_o !== w.nx) report_mismatch("bottom_x", bottom_x_o, w.nx);
        if (bottom_y_o !== w.ny) report_mismatch("bottom_y", bottom_y_o, w.ny);
        if (bottom_z_o !== w.nz) report_mismatch("bottom_z", bottom_z_o, w.nz);
        if (respawned_o !== w.resp) report_mismatch("respawned", respawned_o, w.resp);
        if (frozen_o !== w.frz) report_mismatch("frozen", frozen_o, w.frz);
        n_resp += w.resp;
        n_frz += w.frz;
        n_checked++;
      end
    end
  end

  // ---------------- watchdog ----------------
  int stuck = 0;
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
    else stuck++;
    if (stuck > 5000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  function automatic item_t unit_item(logic first, logic [31:0] wx, logic [31:0] wz);
    item_t it;
    it = '0;
    it.cmd = CmdUnit;
    it.first = first;
    it.wx = wx;
    it.wz = wz;
    return it;
  endfunction

  // Particle with old point inside (mostly) or anywhere.
  function automatic item_t part_item(logic in_box);
    item_t it;
    logic signed [31:0] v [3];
    it = '0;
    it.cmd = CmdPart;
    for (int a = 0; a < 3; a++) begin
      if (in_box && bmin[a] <= bmax[a])
        v[a] = 32'(longint'(bmin[a]) + longint'($urandom())
                   % (longint'(bmax[a]) - longint'(bmin[a]) + 1));
      else
        v[a] = $urandom();
    end
    {it.ox, it.oy, it.oz} = {v[0], v[1], v[2]};
    {it.bx, it.by, it.bz} = {32'($urandom()), 32'($urandom()), 32'($urandom())};
    it.first = $urandom_range(1);
    it.wx = $urandom();
    it.wz = $urandom();
    return it;
  endfunction

  task automatic write_reg(logic [3:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    model_cfg(idx, val);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Wait for all items taken and all segments seen, then let a unit start finish.
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_segs.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_box(logic [31:0] lo[3], logic [31:0] hi[3], int act, int units);
    write_reg(RegMinX, lo[0]);
    write_reg(RegMinY, lo[1]);
    write_reg(RegMinZ, lo[2]);
    write_reg(RegMaxX, hi[0]);
    write_reg(RegMaxY, hi[1]);
    write_reg(RegMaxZ, hi[2]);
    write_reg(RegActive, act);
    write_reg(RegUnits, units);
  endtask

  // Frames of units, each followed by a run of particles.
  task automatic queue_frames(int n_items);
    int made;
    made = 0;
    while (made < n_items) begin
      pending_items.push_back(unit_item(($urandom_range(3) == 0) || made == 0,
                                        $urandom(), $urandom()));
      made++;
      repeat ($urandom_range(2, 12)) begin
        if ($urandom_range(9) == 0) pending_items.push_back(part_item(1'b0));
        else pending_items.push_back(part_item(1'b1));
        made++;
      end
    end
  endtask

  initial begin
    logic [31:0] lo[3], hi[3];
    model_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: particle before any unit start, extremes, frozen.
    lo = '{32'(-256000), 32'(-256000), 32'(-256000)};
    hi = '{32'(256000), 32'(256000), 32'(256000)};
    set_box(lo, hi, 3, 0);   // zero unit count behaves as one
    pending_items.push_back(part_item(1'b1));
    pending_items.push_back(unit_item(1'b1, 32'h7FFF_FFFF, 32'h8000_0000));
    pending_items.push_back(part_item(1'b1));
    pending_items.push_back(part_item(1'b0));
    pending_items.push_back(part_item(1'b1));
    pending_items.push_back(part_item(1'b1));  // frozen
    pending_items.push_back(unit_item(1'b0, 32'h8000_0000, 32'h7FFF_FFFF));
    pending_items.push_back(part_item(1'b1));
    pending_items.push_back(unit_item(1'b0, 32'hFFFF_FFFF, 32'h0));
    for (int i = 0; i < 4; i++) pending_items.push_back(part_item(1'b1));
    drain();

    // Full-range box, inverted box, all frozen, max units.
    lo = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    hi = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    set_box(lo, hi, 256, 256);
    pending_items.push_back(unit_item(1'b1, 32'h0001_0000, 32'hFFFF_0000));
    for (int i = 0; i < 4; i++) pending_items.push_back(part_item(1'b1));
    drain();
    lo = '{32'd5000, 32'd0, 32'd5000};
    hi = '{32'd0, 32'd5000, 32'd0};
    set_box(lo, hi, 0, 511);
    pending_items.push_back(unit_item(1'b1, 32'd100, 32'd100));
    pending_items.push_back(part_item(1'b1));
    drain();
    write_reg(RegActive, 256);
    pending_items.push_back(part_item(1'b1));
    pending_items.push_back(part_item(1'b0));
    drain();

    // Random phases under several settings.
    for (int ph = 0; ph < 6; ph++) begin
      for (int a = 0; a < 3; a++) begin
        lo[a] = 32'(-int'($urandom_range(1 << 20)));
        hi[a] = 32'($urandom_range(1 << 20));
      end
      set_box(lo, hi, (ph == 5) ? 511 : $urandom_range(2, 14),
              (ph == 0) ? 1 : $urandom_range(1, 300));
      quiet = (ph == 2);
      if (ph == 3) want_hold <= 1'b1;
      queue_frames(180);
      drain();
    end
    quiet = 1'b0;

    $display("covered %0d segments: %0d respawned, %0d frozen, six random box settings",
             n_checked, n_resp, n_frz);
    if (errors == 0 && expected_segs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
